@@ src/lzwr_pkg.sv @@
// lzwr_pkg: shared types and constants for the LZW + RLE90 decompressor.
// Used by lzwr_rle and lzw_rle90_decompressor under src/, and by the testbench.
package lzwr_pkg;

  localparam logic [8:0] CLEAR_CODE = 9'd256;
  localparam logic [7:0] ESC_BYTE   = 8'h90;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  // One decoded result on its way to the output register.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    logic [1:0] status;
  } res_t;

endpackage

@@ src/lzwr_ram.sv @@
// lzwr_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module lzwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/lzwr_rle.sv @@
// lzwr_rle: RLE90 expander stage; takes one decoded byte per push.
// Depends on lzwr_pkg.
module lzwr_rle (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              push,
  input  logic [7:0]        byte_in,
  output logic              emit,
  output lzwr_pkg::res_t    res
);
  logic [7:0] prev_r, prev_nxt;
  logic       esc_r, esc_nxt;
  logic       have_r, have_nxt;

  always_comb begin
    prev_nxt = prev_r;
    esc_nxt  = esc_r;
    have_nxt = have_r;
    emit     = 1'b0;
    res      = '{out_byte: byte_in, repeat_count: 8'd1, status: lzwr_pkg::ST_OK};
    if (push) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (byte_in == 8'd0) begin
          emit         = 1'b1;
          res.out_byte = lzwr_pkg::ESC_BYTE;
          prev_nxt     = lzwr_pkg::ESC_BYTE;
          have_nxt     = 1'b1;
        end else if (have_r && byte_in > 8'd1) begin
          emit             = 1'b1;
          res.out_byte     = prev_r;
          res.repeat_count = byte_in - 8'd1;
        end
      end else if (byte_in == lzwr_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        emit     = 1'b1;
        prev_nxt = byte_in;
        have_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      prev_r <= 8'd0;
      esc_r  <= 1'b0;
      have_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      esc_r  <= esc_nxt;
      have_r <= have_nxt;
    end
  end
endmodule

@@ src/lzw_rle90_decompressor.sv @@
// lzw_rle90_decompressor: top level; bit unpacker, LZW sequencer, dictionary RAMs.
// Depends on lzwr_pkg, lzwr_ram and lzwr_rle.
//
// Usage: feed compressed bytes on in_* (tdata = in_byte, tlast = last_byte).
// Results leave on out_* as (out_byte, repeat_count, status) with tlast = run_last
// and tuser = stream_done. in_tready is high only while the sequencer is idle.
// A byte that completes no code goes straight to S_FIN; a clear code, an undefined
// code or the first code of a stream is settled in S_DEC. A valid code is decoded,
// its lengths fetched (S_DEC, S_LREAD, S_LCHK), its prefix chain walked byte by
// byte through the registered-read RAMs (S_WADR, S_WDAT), its bytes pushed one at
// a time into the RLE stage (S_PUSH), and S_FIN finishes. The final result of a
// request is handed over from S_FIN; an end-of-stream byte that produced nothing
// first queues an empty OK result there.
// Each result waits in a pending slot until the next one is produced or the
// request ends, then moves to the output register, held until out_tready; the
// sequencer stalls while both are full. Reset (synchronous, rst_n low) returns
// the unpacker, code width, free-code counter and RLE stage to their start
// values; the dictionary needs no clearing since only entries below the
// free-code counter are read. The end-of-stream byte resets the same state.
module lzw_rle90_decompressor #(
  parameter int MAX_CODE_BITS = 12,
  parameter int STRING_MAX    = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [15:8] repeat_count, [17:16] status
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // stream_done
);
  localparam int CW = MAX_CODE_BITS;
  localparam int NW = MAX_CODE_BITS + 1;
  localparam int LW = $clog2(STRING_MAX + 2);
  localparam int SW = $clog2(STRING_MAX);
  localparam int BW = MAX_CODE_BITS + 8;
  localparam int KW = $clog2(BW + 1);
  localparam logic [NW-1:0] TSIZE = NW'(1) << MAX_CODE_BITS;
  localparam logic [NW-1:0] FIRST_FREE = NW'(257);
  localparam logic [4:0] START_W = 5'd9;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DEC   = 8'b00000010,
    S_LREAD = 8'b00000100,
    S_LCHK  = 8'b00001000,
    S_WADR  = 8'b00010000,
    S_WDAT  = 8'b00100000,
    S_PUSH  = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [BW-1:0]  buf_r, buf_nxt;
  logic [KW-1:0]  cnt_r, cnt_nxt;
  logic [4:0]     width_r, width_nxt;
  logic [NW-1:0]  free_r, free_nxt;
  logic [CW-1:0]  prev_r, prev_nxt;
  logic [7:0]     first_r, first_nxt;
  logic           fresh_r, fresh_nxt;
  logic [CW-1:0]  code_r, code_nxt;
  logic           last_r, last_nxt;
  logic           any_r, any_nxt;
  logic [CW-1:0]  walk_r, walk_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [LW-1:0]  plen_r, plen_nxt;
  logic [LW-1:0]  k_r, k_nxt;
  logic           kwe_r, kwe_nxt;
  logic [7:0]     stk_r [STRING_MAX];
  logic           stk_we;
  logic [SW-1:0]  stk_wa;
  logic [7:0]     stk_wd;

  // output register
  logic           ov_r, ov_nxt;
  lzwr_pkg::res_t ores_r, ores_nxt;
  logic           olast_r, olast_nxt, odone_r, odone_nxt;
  // pending result waiting for the output register
  logic           pv_r, pv_nxt;
  lzwr_pkg::res_t pres_r, pres_nxt;

  // dictionary
  logic           d_we;
  logic [CW-1:0]  d_wa, d_ra;
  logic [CW-1:0]  pfx_rd;
  logic [7:0]     sfx_rd;
  logic [LW-1:0]  len_rd;

  lzwr_ram #(.WIDTH(CW), .DEPTH(1 << CW)) u_pfx (
    .clk, .we(d_we), .waddr(d_wa), .wdata(prev_r), .raddr(d_ra), .rdata(pfx_rd));
  lzwr_ram #(.WIDTH(8), .DEPTH(1 << CW)) u_sfx (
    .clk, .we(d_we), .waddr(d_wa), .wdata(stk_r[0]), .raddr(d_ra), .rdata(sfx_rd));
  lzwr_ram #(.WIDTH(LW), .DEPTH(1 << CW)) u_len (
    .clk, .we(d_we), .waddr(d_wa), .wdata(plen_r + LW'(1)), .raddr(d_ra),
    .rdata(len_rd));

  // RLE stage
  logic           rle_push, rle_clr, rle_emit;
  logic [7:0]     rle_byte;
  lzwr_pkg::res_t rle_res;

  lzwr_rle u_rle (.clk, .rst_n, .clr(rle_clr), .push(rle_push), .byte_in(rle_byte),
    .emit(rle_emit), .res(rle_res));

  logic out_free;
  assign out_free = !ov_r || out_tready;

  always_comb begin
    logic [CW-1:0] c;
    logic [BW-1:0] nb;
    logic [KW-1:0] nc;
    state_nxt = state_r;
    buf_nxt = buf_r; cnt_nxt = cnt_r; width_nxt = width_r; free_nxt = free_r;
    prev_nxt = prev_r; first_nxt = first_r; fresh_nxt = fresh_r;
    code_nxt = code_r; last_nxt = last_r; any_nxt = any_r;
    walk_nxt = walk_r; len_nxt = len_r; plen_nxt = plen_r; k_nxt = k_r;
    kwe_nxt = kwe_r;
    pv_nxt = pv_r; pres_nxt = pres_r;
    ov_nxt = ov_r && !out_tready; ores_nxt = ores_r;
    olast_nxt = olast_r; odone_nxt = odone_r;
    stk_we = 1'b0; stk_wa = '0; stk_wd = 8'd0;
    d_we = 1'b0; d_wa = free_r[CW-1:0]; d_ra = walk_r;
    rle_push = 1'b0; rle_clr = 1'b0; rle_byte = 8'd0;
    in_tready = 1'b0;
    c = '0; nb = '0; nc = '0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = !pv_r;
        if (in_tvalid && !pv_r) begin
          nb = buf_r | (BW'(in_tdata) << cnt_r);
          nc = cnt_r + KW'(8);
          last_nxt = in_tlast;
          any_nxt = 1'b0;
          if (nc >= KW'(width_r)) begin
            c = CW'(nb & ((BW'(1) << width_r) - BW'(1)));
            buf_nxt = nb >> width_r;
            cnt_nxt = nc - KW'(width_r);
            code_nxt = c;
            state_nxt = S_DEC;
          end else begin
            buf_nxt = nb;
            cnt_nxt = nc;
            state_nxt = S_FIN;
          end
        end
      end
      S_DEC: begin
        // fetch previous entry's length
        d_ra = prev_r;
        if (NW'(code_r) == NW'(lzwr_pkg::CLEAR_CODE)) begin
          free_nxt = FIRST_FREE; width_nxt = START_W; fresh_nxt = 1'b1;
          state_nxt = S_FIN;
        end else if (fresh_r) begin
          if (NW'(code_r) < NW'(lzwr_pkg::CLEAR_CODE)) begin
            first_nxt = code_r[7:0]; prev_nxt = code_r; fresh_nxt = 1'b0;
            rle_push = 1'b1; rle_byte = code_r[7:0];
            if (rle_emit) begin
              pv_nxt = 1'b1; pres_nxt = rle_res;
            end
          end else begin
            pv_nxt = 1'b1;
            pres_nxt = '{out_byte: 8'd0, repeat_count: 8'd0,
                         status: lzwr_pkg::ST_UNDEF};
          end
          state_nxt = S_FIN;
        end else if (NW'(code_r) > free_r || (NW'(code_r) == free_r && free_r >= TSIZE))
        begin
          pv_nxt = 1'b1;
          pres_nxt = '{out_byte: 8'd0, repeat_count: 8'd0, status: lzwr_pkg::ST_UNDEF};
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_LREAD;
        end
      end
      S_LREAD: begin
        // previous length arrives; launch read of code length
        plen_nxt = (NW'(prev_r) < NW'(lzwr_pkg::CLEAR_CODE)) ? LW'(1) : len_rd;
        d_ra = code_r;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        logic adding, is_new;
        logic [LW-1:0] nl;
        adding = free_r < TSIZE;
        is_new = NW'(code_r) == free_r;
        nl = plen_r + LW'(1);
        state_nxt = S_FIN;
        if ((adding || is_new) && nl > LW'(STRING_MAX)) begin
          pv_nxt = 1'b1;
          pres_nxt = '{out_byte: 8'd0, repeat_count: 8'd0, status: lzwr_pkg::ST_LONG};
        end else if (is_new) begin
          len_nxt = nl;
          walk_nxt = prev_r;
          k_nxt = plen_r;
          stk_we = 1'b1; stk_wa = SW'(nl - LW'(1)); stk_wd = first_r;
          state_nxt = S_WADR;
        end else begin
          len_nxt = (NW'(code_r) < NW'(lzwr_pkg::CLEAR_CODE)) ? LW'(1) : len_rd;
          walk_nxt = code_r;
          k_nxt = len_nxt;
          if (len_nxt == '0 || len_nxt > LW'(STRING_MAX)) begin
            pv_nxt = 1'b1;
            pres_nxt = '{out_byte: 8'd0, repeat_count: 8'd0,
                         status: lzwr_pkg::ST_LONG};
          end else begin
            state_nxt = S_WADR;
          end
        end
      end
      S_WADR: begin
        // walk_r is driving the RAM address this cycle
        if (k_r <= LW'(1)) begin
          stk_we = 1'b1; stk_wa = '0; stk_wd = walk_r[7:0];
          state_nxt = S_WDAT;
          k_nxt = '0;
          kwe_nxt = 1'b1;
        end else begin
          state_nxt = S_WDAT;
          kwe_nxt = 1'b0;
        end
      end
      S_WDAT: begin
        if (kwe_r) begin
          // chain done: update table and start pushing
          if (free_r < TSIZE) begin
            d_we = 1'b1;
            free_nxt = free_r + NW'(1);
            if (width_r < 5'(MAX_CODE_BITS) && free_nxt == (NW'(1) << width_r)) begin
              width_nxt = width_r + 5'd1;
            end
          end
          first_nxt = stk_r[0];
          prev_nxt = code_r;
          k_nxt = '0;
          state_nxt = S_PUSH;
        end else begin
          stk_we = 1'b1; stk_wa = SW'(k_r - LW'(1)); stk_wd = sfx_rd;
          walk_nxt = pfx_rd;
          k_nxt = k_r - LW'(1);
          state_nxt = S_WADR;
        end
      end
      S_PUSH: begin
        if (k_r == len_r) begin
          state_nxt = S_FIN;
        end else if (!pv_r || out_free) begin
          rle_push = 1'b1;
          rle_byte = stk_r[SW'(k_r)];
          k_nxt = k_r + LW'(1);
          if (rle_emit) begin
            pv_nxt = 1'b1; pres_nxt = rle_res;
          end
        end
      end
      S_FIN: begin
        if (!pv_r) begin
          if (last_r) begin
            if (!any_r) begin
              pv_nxt = 1'b1;
              pres_nxt = '{out_byte: 8'd0, repeat_count: 8'd0, status: lzwr_pkg::ST_OK};
            end
            if (!any_r) begin
              state_nxt = S_FIN;
              any_nxt = 1'b1;
            end else begin
              buf_nxt = '0; cnt_nxt = '0; width_nxt = START_W; free_nxt = FIRST_FREE;
              prev_nxt = '0; first_nxt = 8'd0; fresh_nxt = 1'b1; rle_clr = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // move the pending result to the output register; it is the last one
    // only once the sequencer has reached the end with nothing else queued
    if (pv_r && out_free && (state_r == S_FIN || (rle_push && rle_emit))) begin
      ov_nxt = 1'b1;
      ores_nxt = pres_r;
      odone_nxt = last_r;
      olast_nxt = 1'b0;
      pv_nxt = rle_push && rle_emit;
      any_nxt = 1'b1;
      if (state_r == S_FIN) begin
        olast_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_r[stk_wa] <= stk_wd;
    end
    ores_r <= ores_nxt;
    pres_r <= pres_nxt;
    code_r <= code_nxt; walk_r <= walk_nxt; len_r <= len_nxt; plen_r <= plen_nxt;
    k_r <= k_nxt; kwe_r <= kwe_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      buf_r <= '0; cnt_r <= '0; width_r <= START_W; free_r <= FIRST_FREE;
      prev_r <= '0; first_r <= 8'd0; fresh_r <= 1'b1;
      last_r <= 1'b0; any_r <= 1'b0;
      ov_r <= 1'b0; pv_r <= 1'b0; olast_r <= 1'b0; odone_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buf_r <= buf_nxt; cnt_r <= cnt_nxt; width_r <= width_nxt; free_r <= free_nxt;
      prev_r <= prev_nxt; first_r <= first_nxt; fresh_r <= fresh_nxt;
      last_r <= last_nxt; any_r <= any_nxt;
      ov_r <= ov_nxt; pv_r <= pv_nxt; olast_r <= olast_nxt; odone_r <= odone_nxt;
    end
  end

  // pending results only move when no further result can follow before the
  // next one is queued: a newly queued result pushes the older one out as
  // not-last, and the final one moves in S_FIN as last.
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, ores_r.status, ores_r.repeat_count, ores_r.out_byte};
  assign out_tlast  = olast_r;
  assign out_tuser  = odone_r;
endmodule

@@ src/lzwr_checker.sv @@
// lzwr_checker: port-level assertions for lzw_rle90_decompressor, bound below.
// Depends only on the top level's ports.
module lzwr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:16] != 2'd3)
    else $error("bad status code");
  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] != 2'd0 |-> out_tdata[15:8] == 8'd0)
    else $error("error result carries a byte");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted two requests back to back");
endmodule

bind lzw_rle90_decompressor lzwr_checker u_lzwr_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata,
  .out_tlast);

@@ sim/lzw_rle90_decompressor_test.sv @@
// Self-checking testbench for lzw_rle90_decompressor: packed LZW code streams in,
// (byte, repeat count, status) results checked against a bit-true predictor.
// Depends on lzwr_pkg and the RTL under src/.
`timescale 1ns / 1ps

module lzw_rle90_decompressor_test;
  localparam int CODE_CLEAR = 256;
  localparam int FIRST_FREE = 257;
  localparam int TBL_SIZE   = 4096;
  localparam int MAX_BITS   = 12;
  localparam int STR_MAX    = 24;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [7:0] b;
    logic [7:0] cnt;
    logic       lst;
    logic       done;
    logic [1:0] st;
  } run_res_t;

  class lzw_scoreboard;
    int unsigned bit_buf, bit_cnt, width, nfc, prev_code, first_ch;
    bit          fresh;
    bit [11:0]   pfx[TBL_SIZE];
    bit [7:0]    sfx[TBL_SIZE];
    bit [4:0]    lens[TBL_SIZE];
    bit [7:0]    stk[STR_MAX];
    bit [7:0]    rle_prev;
    bit          rle_esc, rle_have;
    run_res_t    step_q[$];
    run_res_t    pending_q[$];
    int          errors, results;

    function void restart();
      bit_buf = 0; bit_cnt = 0; width = 9; nfc = FIRST_FREE;
      prev_code = 0; first_ch = 0; fresh = 1;
      rle_prev = 0; rle_esc = 0; rle_have = 0;
    endfunction

    function new();
      restart();
      errors = 0;
      results = 0;
    endfunction

    function void add(logic [7:0] b, logic [7:0] cnt, logic [1:0] st);
      run_res_t r;
      r.b = b; r.cnt = cnt; r.st = st; r.lst = 0; r.done = 0;
      step_q.push_back(r);
    endfunction

    function void rle_push(bit [7:0] b);
      if (rle_esc) begin
        rle_esc = 0;
        if (b == 0) begin
          add(lzwr_pkg::ESC_BYTE, 1, lzwr_pkg::ST_OK);
          rle_prev = lzwr_pkg::ESC_BYTE;
          rle_have = 1;
        end else if (rle_have && b > 1) begin
          add(rle_prev, b - 8'd1, lzwr_pkg::ST_OK);
        end
      end else if (b == lzwr_pkg::ESC_BYTE) begin
        rle_esc = 1;
      end else begin
        add(b, 1, lzwr_pkg::ST_OK);
        rle_prev = b;
        rle_have = 1;
      end
    endfunction

    function int unsigned str_len(int unsigned e);
      return (e < CODE_CLEAR) ? 1 : lens[e];
    endfunction

    function void expand(int unsigned e, int unsigned n);
      int unsigned k;
      k = n;
      while (k > 1) begin
        stk[k-1] = sfx[e];
        e = pfx[e];
        k--;
      end
      stk[0] = e[7:0];
    endfunction

    function void decode(int unsigned c);
      int unsigned plen, nlen, slen;
      bit adding;
      if (c == CODE_CLEAR) begin
        nfc = FIRST_FREE; width = 9; fresh = 1;
        return;
      end
      if (fresh) begin
        if (c < CODE_CLEAR) begin
          first_ch = c; prev_code = c; fresh = 0;
          rle_push(c[7:0]);
        end else add(0, 0, lzwr_pkg::ST_UNDEF);
        return;
      end
      if (c > nfc || (c == nfc && nfc >= TBL_SIZE)) begin
        add(0, 0, lzwr_pkg::ST_UNDEF);
        return;
      end
      plen = str_len(prev_code);
      nlen = plen + 1;
      adding = nfc < TBL_SIZE;
      if ((adding || c == nfc) && nlen > STR_MAX) begin
        add(0, 0, lzwr_pkg::ST_LONG);
        return;
      end
      if (c == nfc) begin
        slen = nlen;
        expand(prev_code, plen);
        stk[slen-1] = first_ch[7:0];
      end else begin
        slen = str_len(c);
        if (slen == 0 || slen > STR_MAX) begin
          add(0, 0, lzwr_pkg::ST_LONG);
          return;
        end
        expand(c, slen);
      end
      if (adding) begin
        pfx[nfc] = prev_code[11:0];
        sfx[nfc] = stk[0];
        lens[nfc] = nlen[4:0];
        nfc++;
        if (width < MAX_BITS && nfc == (1 << width)) width++;
      end
      first_ch = stk[0];
      prev_code = c;
      for (int i = 0; i < slen; i++) rle_push(stk[i]);
    endfunction

    // Note one accepted request and queue the results it must cause.
    function void note_input(logic [7:0] b, logic last);
      int unsigned c;
      step_q.delete();
      bit_buf |= int'(b) << bit_cnt;
      bit_cnt += 8;
      if (bit_cnt >= width) begin
        c = bit_buf & ((1 << width) - 1);
        bit_buf >>= width;
        bit_cnt -= width;
        decode(c);
      end
      if (last) begin
        if (step_q.size() == 0) add(0, 0, lzwr_pkg::ST_OK);
        restart();
      end
      foreach (step_q[i]) begin
        step_q[i].done = last;
        step_q[i].lst = (i == step_q.size() - 1);
        pending_q.push_back(step_q[i]);
      end
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check(logic [7:0] b, logic [7:0] cnt, logic lst, logic done, logic [1:0] st);
      run_res_t e;
      results++;
      if (pending_q.size() == 0) begin
        report("unexpected result, byte", b, -1);
        return;
      end
      e = pending_q.pop_front();
      if (b !== e.b) report("out_byte", b, e.b);
      if (cnt !== e.cnt) report("repeat_count", cnt, e.cnt);
      if (lst !== e.lst) report("run_last", lst, e.lst);
      if (done !== e.done) report("stream_done", done, e.done);
      if (st !== e.st) report("status", st, e.st);
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready, out_tlast, out_tuser;
  logic [23:0] out_tdata;

  lzw_rle90_decompressor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  lzw_scoreboard sb = new();
  int  cycles = 0;
  int  hold_left = 0;
  int  bytes_sent = 0;
  int  streams = 0;
  bit  calm = 0;

  // Encoder-side view of the decoder, kept in step so codes pack at the right width.
  int unsigned g_nfc, g_w, g_prev, acc, acc_n;
  bit          g_fresh;
  bit [4:0]    g_len[TBL_SIZE];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        sb.check(out_tdata[7:0], out_tdata[15:8], out_tlast, out_tuser, out_tdata[17:16]);
    end
  end

  // Result side: random short stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1;
      end
    end
  end

  task send_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task gen_restart();
    g_nfc = FIRST_FREE; g_w = 9; g_prev = 0; g_fresh = 1;
    acc = 0; acc_n = 0;
  endtask

  function int unsigned g_strlen(int unsigned e);
    return (e < CODE_CLEAR) ? 1 : g_len[e];
  endfunction

  // Pack one code at the current width, then advance the encoder-side view.
  task put_code(int unsigned c);
    int unsigned nl;
    acc |= (c & ((1 << g_w) - 1)) << acc_n;
    acc_n += g_w;
    if (c == CODE_CLEAR) begin
      g_nfc = FIRST_FREE; g_w = 9; g_fresh = 1;
    end else if (g_fresh) begin
      if (c < CODE_CLEAR) begin
        g_prev = c; g_fresh = 0;
      end
    end else if (!(c > g_nfc || (c == g_nfc && g_nfc >= TBL_SIZE))) begin
      nl = g_strlen(g_prev) + 1;
      if (!((g_nfc < TBL_SIZE || c == g_nfc) && nl > STR_MAX)) begin
        if (g_nfc < TBL_SIZE) begin
          g_len[g_nfc] = nl[4:0];
          g_nfc++;
          if (g_w < MAX_BITS && g_nfc == (1 << g_w)) g_w++;
        end
        g_prev = c;
      end
    end
    while (acc_n >= 8) begin
      send_byte(acc[7:0], 0);
      acc >>= 8;
      acc_n -= 8;
    end
  endtask

  // Flush leftover bits in a final byte marked last.
  task end_stream();
    send_byte(acc[7:0], 1);
    streams++;
    gen_restart();
  endtask

  function int unsigned pick_literal();
    unique case ($urandom_range(0, 7))
      0, 1: return lzwr_pkg::ESC_BYTE;
      2:    return $urandom_range(0, 2);
      3:    return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function int unsigned pick_code();
    int unsigned sel;
    if (g_fresh)
      return ($urandom_range(0, 9) == 0) ? $urandom_range(FIRST_FREE, 511) : pick_literal();
    sel = $urandom_range(0, 19);
    if (sel < 9) return pick_literal();
    if (sel < 13 && g_nfc > FIRST_FREE) return $urandom_range(FIRST_FREE, g_nfc - 1);
    if (sel < 16) return g_nfc;
    if (sel == 16) return CODE_CLEAR;
    if (sel == 17 && g_nfc + 1 < (1 << g_w)) return $urandom_range(g_nfc + 1, (1 << g_w) - 1);
    return pick_literal();
  endfunction

  // Drop the request line and wait until every expected result is back.
  task wait_drained();
    in_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int n;
    bit held;
    held = 0;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= 0;
    in_tlast <= 0;
    gen_restart();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: literals, escaped 0x90, a run, run of one, code equal to next
    // free code, known code, undefined code, clear, bad first code after clear.
    put_code(8'h41); put_code(lzwr_pkg::ESC_BYTE); put_code(0);
    put_code(8'h42); put_code(lzwr_pkg::ESC_BYTE); put_code(5);
    put_code(lzwr_pkg::ESC_BYTE); put_code(1);
    put_code(g_nfc); put_code(FIRST_FREE); put_code(g_nfc + 3);
    put_code(CODE_CLEAR); put_code(300); put_code(255); put_code(0);
    end_stream();
    // Run with no byte before it, and a stream holding no code.
    put_code(lzwr_pkg::ESC_BYTE); put_code(3); put_code(lzwr_pkg::ESC_BYTE);
    end_stream();
    send_byte(8'h00, 1);
    streams++;
    // Chain of ever longer strings until one exceeds the limit.
    put_code(8'h61);
    repeat (STR_MAX + 1) put_code(g_nfc);
    end_stream();

    // Sender pause until all results are back.
    wait_drained();

    // Random streams; a long result-side hold-off fills the block mid-way.
    n = bytes_sent;
    while (bytes_sent - n < 70) begin
      if (!held && bytes_sent - n > 20) begin
        hold_left = 300;
        held = 1;
      end
      if (bytes_sent - n > 55) calm = 1;
      repeat ($urandom_range(3, 20)) put_code(pick_code());
      end_stream();
    end

    wait_drained();
    $display("covered %0d compressed bytes in %0d streams, %0d results checked",
             bytes_sent, streams, sb.results);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lzwr_pkg.sv
src/lzwr_ram.sv
src/lzwr_rle.sv
src/lzw_rle90_decompressor.sv
src/lzwr_checker.sv
sim/lzw_rle90_decompressor_test.sv
